/* rtl/dscc_pkg.sv */
// Shared types, codes and constants of the dual servo command controller.
package dscc_pkg;

    localparam int DUTY_BITS_DEF = 13;
    localparam int SERVO_COUNT   = 2;
    localparam int SERVO_W       = $clog2(SERVO_COUNT);
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    localparam int ANGLE_W    = 13;
    localparam int DUR_W      = 16;
    localparam int TRIM_W     = 11;
    localparam int CNT_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CLAMP_W    = 11;
    localparam int PULSE_W    = 12;

    localparam int FULL_TENTHS   = 1800;
    localparam int PULSE_MIN_US  = 500;
    localparam int PERIOD_US     = 20000;
    localparam int TIMEOUT_RESET = 1000;

    // floor(v/9) for v = a*10 as (a * 72810) >> 16, one correction step after
    localparam int DIV9_MUL   = 72810;
    localparam int DIV9_SHIFT = 16;
    // floor(x/20000) as (x * floor(2^32/20000)) >> 32, one correction step after
    localparam int  RECIP_SHIFT = 32;
    localparam longint RECIP_MUL = (64'd1 << RECIP_SHIFT) / PERIOD_US;

    localparam logic [1:0] FUNC_SINGLE = 2'd0;
    localparam logic [1:0] FUNC_SYNC   = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] JOB_SINGLE = 2'd0;
    localparam logic [1:0] JOB_SYNC   = 2'd1;
    localparam logic [1:0] JOB_OFF    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TRIM_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

    typedef struct packed {
        logic [1:0]                kind;
        logic [SERVO_W-1:0]        servo;
        logic signed [ANGLE_W-1:0] a1;
        logic signed [ANGLE_W-1:0] a2;
        logic [DUR_W-1:0]          dur;
    } t_job;

    typedef struct packed {
        logic               is_event;
        logic [SERVO_W-1:0] servo;
        logic [DUR_W-1:0]   fade;
        logic               last;
    } t_tag;

    typedef struct packed {
        logic signed [TRIM_W-1:0] trim_left;
        logic signed [TRIM_W-1:0] trim_right;
        logic                     inv_left;
        logic                     inv_right;
    } t_cfg;

    typedef struct packed {
        logic             supply_on;
        logic [CNT_W-1:0] countdown;
    } t_front_stat;

endpackage

/* rtl/dual_servo_command_controller.sv */
// Path: a command passes the job queue, the registered duty pipeline and the result queue
//   before it shows on the output; the second servo of a synchronous move follows the first.
// Throughput: one input transaction per cycle while the job queue has room; a
//   synchronous move issues into the duty pipeline once per servo.
// Reset: synchronous, active low; clears queues, pipeline valids, supply state and
//   loads the configuration defaults (trims 0, no inversion, 1000 ms idle timeout).
module dual_servo_command_controller import dscc_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command side
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_func,
    input  logic [SERVO_W-1:0]        i_servo_index,
    input  logic signed [ANGLE_W-1:0] i_angle_first,
    input  logic signed [ANGLE_W-1:0] i_angle_second,
    input  logic [DUR_W-1:0]          i_duration_ms,
    // result side
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_event_kind,
    output logic [SERVO_W-1:0]        o_out_servo,
    output logic [DUTY_BITS-1:0]      o_duty,
    output logic [DUR_W-1:0]          o_fade_ms,
    output logic                      o_power_enable,
    output logic                      o_last,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int RES_W = 1 + SERVO_W + DUTY_BITS + DUR_W + 2;
    localparam int JOB_W = $bits(t_job);

    // configuration registers
    logic signed [TRIM_W-1:0] r_trim_left, r_trim_right;
    logic                     r_inv_left, r_inv_right;
    logic [DUR_W-1:0]         r_idle_timeout;
    t_cfg                     s_cfg;

    logic        s_accept;
    logic        s_job_push, s_job_pop, s_mid_full, s_mid_empty;
    t_job        s_job_in, s_job_head;
    logic [JOB_W-1:0] s_job_head_bits;
    t_front_stat s_stat;

    logic             s_res_push, s_res_full;
    logic [RES_W-1:0] s_res_in, s_res_out;

    // Config port never stalls; the user must make writes only while the block is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_left    <= '0;
            r_trim_right   <= '0;
            r_inv_left     <= 1'b0;
            r_inv_right    <= 1'b0;
            r_idle_timeout <= DUR_W'(TIMEOUT_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TRIM_LEFT:    r_trim_left    <= i_cfg_data[TRIM_W-1:0];
                REG_TRIM_RIGHT:   r_trim_right   <= i_cfg_data[TRIM_W-1:0];
                REG_INV_LEFT:     r_inv_left     <= i_cfg_data[0];
                REG_INV_RIGHT:    r_inv_right    <= i_cfg_data[0];
                REG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[DUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_cfg.trim_left  = r_trim_left;
    assign s_cfg.trim_right = r_trim_right;
    assign s_cfg.inv_left   = r_inv_left;
    assign s_cfg.inv_right  = r_inv_right;

    // A transaction is taken whenever the job queue has room, ticks included.
    assign full     = s_mid_full;
    assign s_accept = push && !full;

    dscc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_func         (i_func),
        .i_servo_index  (i_servo_index),
        .i_angle_first  (i_angle_first),
        .i_angle_second (i_angle_second),
        .i_duration_ms  (i_duration_ms),
        .i_idle_timeout (r_idle_timeout),
        .o_job_push     (s_job_push),
        .o_job          (s_job_in),
        .o_stat         (s_stat)
    );

    // Job queue decouples command intake from duty computation.
    dscc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_job_push),
        .i_data  (s_job_in),
        .o_full  (s_mid_full),
        .i_pop   (s_job_pop),
        .o_empty (s_mid_empty),
        .o_data  (s_job_head_bits)
    );

    assign s_job_head = t_job'(s_job_head_bits);

    dscc_back #(
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (s_job_head),
        .i_job_empty (s_mid_empty),
        .o_job_pop   (s_job_pop),
        .i_cfg       (s_cfg),
        .i_res_full  (s_res_full),
        .o_res_push  (s_res_push),
        .o_res_data  (s_res_in)
    );

    // Result queue: holds finished results while the consumer stalls.
    dscc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_push),
        .i_data  (s_res_in),
        .o_full  (s_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (s_res_out)
    );

    // Unpack: event kind, servo, duty, fade, power, last (msb first).
    assign o_event_kind   = s_res_out[RES_W-1];
    assign o_out_servo    = s_res_out[RES_W-2 -: SERVO_W];
    assign o_duty         = s_res_out[DUR_W + 2 +: DUTY_BITS];
    assign o_fade_ms      = s_res_out[2 +: DUR_W];
    assign o_power_enable = s_res_out[1];
    assign o_last         = s_res_out[0];

`ifndef ASSERT_OFF
    a_move_powers_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_func == FUNC_SINGLE || i_func == FUNC_SYNC))
        |=> s_stat.supply_on)
        else $error("supply not on after a move");

    a_timer_matches_supply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.supply_on == (s_stat.countdown != '0))
        else $error("supply state and countdown disagree");

    a_off_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind) |-> (!o_power_enable && o_duty == '0 && o_last))
        else $error("malformed power-off event");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_push |-> !s_res_full)
        else $error("result pushed into full queue");
`endif

endmodule

/* rtl/dscc_fifo.sv */
// Small register queue used between front and back and on the result side.
module dscc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             s_do_push, s_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign s_do_push = i_push && !o_full;
    assign s_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (s_do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (s_do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (s_do_push && !s_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (s_do_pop && !s_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/dscc_front.sv */
// Front end: takes commands and ticks, keeps the supply timer, queues jobs.
module dscc_front import dscc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_func,
    input  logic [SERVO_W-1:0]        i_servo_index,
    input  logic signed [ANGLE_W-1:0] i_angle_first,
    input  logic signed [ANGLE_W-1:0] i_angle_second,
    input  logic [DUR_W-1:0]          i_duration_ms,
    input  logic [DUR_W-1:0]          i_idle_timeout,
    output logic                      o_job_push,
    output t_job                      o_job,
    output t_front_stat               o_stat
);

    logic             r_supply_on, n_supply_on;
    logic [CNT_W-1:0] r_countdown, n_countdown;
    logic [DUR_W-1:0] s_dur_eff;

    assign s_dur_eff = (i_duration_ms == '0) ? DUR_W'(1) : i_duration_ms;

    always_comb begin
        n_supply_on   = r_supply_on;
        n_countdown   = r_countdown;
        o_job_push    = 1'b0;
        o_job.kind    = JOB_SINGLE;
        o_job.servo   = i_servo_index;
        o_job.a1      = i_angle_first;
        o_job.a2      = i_angle_second;
        o_job.dur     = i_duration_ms;
        if (i_accept) begin
            case (i_func)
                FUNC_SINGLE, FUNC_SYNC: begin
                    n_supply_on = 1'b1;
                    n_countdown = CNT_W'(s_dur_eff) + CNT_W'(i_idle_timeout);
                    o_job_push  = 1'b1;
                    o_job.kind  = (i_func == FUNC_SYNC) ? JOB_SYNC : JOB_SINGLE;
                end
                FUNC_TICK: begin
                    if (r_supply_on) begin
                        if (r_countdown <= CNT_W'(1)) begin
                            // expire: drop supply and report it on servo 0
                            n_countdown = '0;
                            n_supply_on = 1'b0;
                            o_job_push  = 1'b1;
                            o_job.kind  = JOB_OFF;
                            o_job.servo = SERVO_W'(0);
                        end else begin
                            n_countdown = r_countdown - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply_on <= 1'b0;
            r_countdown <= '0;
        end else begin
            r_supply_on <= n_supply_on;
            r_countdown <= n_countdown;
        end
    end

    assign o_stat.supply_on = r_supply_on;
    assign o_stat.countdown = r_countdown;

endmodule

/* rtl/dscc_back.sv */
// Back end: expands jobs into results and runs the angle to duty pipeline.
module dscc_back import dscc_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_empty,
    output logic       o_job_pop,
    input  t_cfg       i_cfg,
    input  logic       i_res_full,
    output logic       o_res_push,
    output logic [1 + SERVO_W + DUTY_BITS + DUR_W + 1:0] o_res_data
);

    localparam int XW   = PULSE_W + DUTY_BITS;
    localparam int PRW  = DUTY_BITS + RECIP_SHIFT;
    localparam int V10W = 15;
    localparam int P9W  = 28;
    localparam logic signed [15:0] FULL_S = 16'(FULL_TENTHS);

    logic s_en, s_issue, s_sync, s_first_half;
    logic r_half;

    logic r_v1, r_v2, r_v3, r_v4;
    t_tag s_tag0, r_tag1, r_tag2, r_tag3, r_tag4;

    logic signed [ANGLE_W-1:0] s_ang_sel;
    logic signed [15:0]        s_ang_in, s_ang_m, s_ang_f, s_ang_t, s_trim;
    logic                      s_inv;
    logic [CLAMP_W-1:0]        s_ang_c, r_ang;

    logic [P9W-1:0]     s_prod9;
    logic [CLAMP_W-1:0] r_q9;
    logic [V10W-1:0]    r_v10, s_rem9;
    logic [PULSE_W-1:0] r_pulse;

    logic [XW-1:0]        s_x, r_x;
    logic [PRW-1:0]       s_prodr;
    logic [DUTY_BITS-1:0] r_dq, s_duty;
    logic [XW:0]          s_qm, s_remr;

    // pipeline moves unless the last stage holds a result the queue cannot take
    assign s_en         = !r_v4 || !i_res_full;
    assign s_sync       = (i_job.kind == JOB_SYNC);
    assign s_first_half = s_sync && !r_half;
    assign s_issue      = s_en && !i_job_empty;
    assign o_job_pop    = s_issue && !s_first_half;

    always_comb begin
        s_tag0.is_event = (i_job.kind == JOB_OFF);
        s_tag0.servo    = s_sync ? SERVO_W'(r_half) : i_job.servo;
        s_tag0.fade     = s_tag0.is_event ? '0 : i_job.dur;
        s_tag0.last     = !s_first_half;
    end

    // mirror, invert (cross-assigned flags), trim, clamp
    always_comb begin
        s_ang_sel = (s_sync && r_half) ? i_job.a2 : i_job.a1;
        s_ang_in  = {{(16 - ANGLE_W){s_ang_sel[ANGLE_W-1]}}, s_ang_sel};
        s_ang_m   = s_tag0.servo[0] ? (FULL_S - s_ang_in) : s_ang_in;
        s_inv     = s_tag0.servo[0] ? i_cfg.inv_left : i_cfg.inv_right;
        s_ang_f   = s_inv ? (FULL_S - s_ang_m) : s_ang_m;
        s_trim    = s_tag0.servo[0] ?
                    {{(16 - TRIM_W){i_cfg.trim_right[TRIM_W-1]}}, i_cfg.trim_right} :
                    {{(16 - TRIM_W){i_cfg.trim_left[TRIM_W-1]}}, i_cfg.trim_left};
        s_ang_t   = s_ang_f + s_trim;
        if (s_ang_t < 16'sd0) begin
            s_ang_c = '0;
        end else if (s_ang_t > FULL_S) begin
            s_ang_c = CLAMP_W'(FULL_TENTHS);
        end else begin
            s_ang_c = s_ang_t[CLAMP_W-1:0];
        end
    end

    assign s_prod9 = P9W'(r_ang) * P9W'(DIV9_MUL);
    assign s_rem9  = r_v10 - V10W'(r_q9) * V10W'(9);
    assign s_x     = (XW'(r_pulse) << DUTY_BITS) - XW'(r_pulse);
    assign s_prodr = PRW'(s_x) * PRW'(RECIP_MUL);
    assign s_qm    = (XW + 1)'(r_dq) * (XW + 1)'(PERIOD_US);
    assign s_remr  = {1'b0, r_x} - s_qm;
    assign s_duty  = r_dq + DUTY_BITS'(s_remr >= (XW + 1)'(PERIOD_US));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
        end else if (s_en) begin
            if (s_issue) begin
                r_half <= s_first_half;
            end
            r_v1 <= s_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_tag1  <= s_tag0;
            r_ang   <= s_ang_c;
            r_tag2  <= r_tag1;
            r_q9    <= s_prod9[DIV9_SHIFT +: CLAMP_W];
            r_v10   <= V10W'(r_ang) * V10W'(10);
            r_tag3  <= r_tag2;
            r_pulse <= PULSE_W'(PULSE_MIN_US) + PULSE_W'(r_q9)
                       + PULSE_W'(s_rem9 >= V10W'(9));
            r_tag4  <= r_tag3;
            r_x     <= s_x;
            r_dq    <= s_prodr[RECIP_SHIFT +: DUTY_BITS];
        end
    end

    assign o_res_push = r_v4 && !i_res_full;
    assign o_res_data = {r_tag4.is_event, r_tag4.servo,
                         r_tag4.is_event ? DUTY_BITS'(0) : s_duty,
                         r_tag4.fade, !r_tag4.is_event, r_tag4.last};

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the dual servo command controller, scoreboard and stimulus in one file.

localparam logic       EV_DUTY      = 1'b0;
localparam logic       EV_POWER_OFF = 1'b1;
localparam logic [1:0] FUNC_UNUSED  = 2'd3;

typedef struct packed {
    logic                               kind;
    logic [dscc_pkg::SERVO_W-1:0]       servo;
    logic [dscc_pkg::DUTY_BITS_DEF-1:0] duty;
    logic [dscc_pkg::DUR_W-1:0]         fade;
    logic                               power;
    logic                               last;
} t_servo_result;

class servo_scoreboard;
    int            trim_left;
    int            trim_right;
    bit            inv_left;
    bit            inv_right;
    int            idle_ms;
    bit            supply_on;
    int            off_count;
    t_servo_result pending_results[$];
    int            errors;
    int            n_results;
    int            n_moves;
    int            n_syncs;
    int            n_ticks;
    int            n_events;
    int            n_writes;

    function new();
        idle_ms = dscc_pkg::TIMEOUT_RESET;
    endfunction

    function void write_reg(logic [dscc_pkg::CFG_IDX_W-1:0] idx,
                            logic [dscc_pkg::CFG_DATA_W-1:0] data);
        logic signed [dscc_pkg::TRIM_W-1:0] trim_val;
        trim_val = data[dscc_pkg::TRIM_W-1:0];
        n_writes++;
        case (idx)
            dscc_pkg::REG_TRIM_LEFT:    trim_left  = trim_val;
            dscc_pkg::REG_TRIM_RIGHT:   trim_right = trim_val;
            dscc_pkg::REG_INV_LEFT:     inv_left   = data[0];
            dscc_pkg::REG_INV_RIGHT:    inv_right  = data[0];
            dscc_pkg::REG_IDLE_TIMEOUT: idle_ms    = data;
            default: ;
        endcase
    endfunction

    // Mirror servo 1, apply the crossed inversion flag, trim, clamp, then scale.
    function logic [dscc_pkg::DUTY_BITS_DEF-1:0] servo_duty(logic servo, int angle);
        int a;
        int pulse;
        a = servo ? dscc_pkg::FULL_TENTHS - angle : angle;
        if (servo ? inv_left : inv_right)
            a = dscc_pkg::FULL_TENTHS - a;
        a += servo ? trim_right : trim_left;
        if (a < 0)
            a = 0;
        else if (a > dscc_pkg::FULL_TENTHS)
            a = dscc_pkg::FULL_TENTHS;
        pulse = dscc_pkg::PULSE_MIN_US + (a * 10) / 9;
        return dscc_pkg::DUTY_BITS_DEF'(
            (pulse * ((1 << dscc_pkg::DUTY_BITS_DEF) - 1)) / dscc_pkg::PERIOD_US);
    endfunction

    function void add_result(logic kind, logic servo,
                             logic [dscc_pkg::DUTY_BITS_DEF-1:0] duty,
                             logic [dscc_pkg::DUR_W-1:0] fade, logic power, logic last);
        t_servo_result r;
        r.kind  = kind;
        r.servo = servo;
        r.duty  = duty;
        r.fade  = fade;
        r.power = power;
        r.last  = last;
        pending_results.push_back(r);
    endfunction

    function void note_command(logic [1:0] func, logic servo,
                               logic signed [dscc_pkg::ANGLE_W-1:0] a1,
                               logic signed [dscc_pkg::ANGLE_W-1:0] a2,
                               logic [dscc_pkg::DUR_W-1:0] dur);
        int hold;
        if (func == dscc_pkg::FUNC_SINGLE || func == dscc_pkg::FUNC_SYNC) begin
            supply_on = 1'b1;
            hold      = (dur == 0) ? 1 : dur;
            off_count = hold + idle_ms;
            if (func == dscc_pkg::FUNC_SINGLE) begin
                n_moves++;
                add_result(EV_DUTY, servo, servo_duty(servo, a1), dur, 1'b1, 1'b1);
            end else begin
                n_syncs++;
                add_result(EV_DUTY, 1'b0, servo_duty(1'b0, a1), dur, 1'b1, 1'b0);
                add_result(EV_DUTY, 1'b1, servo_duty(1'b1, a2), dur, 1'b1, 1'b1);
            end
        end else if (func == dscc_pkg::FUNC_TICK && supply_on) begin
            n_ticks++;
            if (off_count <= 1) begin
                off_count = 0;
                supply_on = 1'b0;
                n_events++;
                add_result(EV_POWER_OFF, 1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
                off_count--;
            end
        end
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(t_servo_result got);
        t_servo_result want;
        n_results++;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d servo %0d duty %0d",
                     $time, got.kind, got.servo, got.duty);
            return;
        end
        want = pending_results.pop_front();
        compare_field("event_kind",   want.kind,  got.kind);
        compare_field("out_servo",    want.servo, got.servo);
        compare_field("duty",         want.duty,  got.duty);
        compare_field("fade_ms",      want.fade,  got.fade);
        compare_field("power_enable", want.power, got.power);
        compare_field("last",         want.last,  got.last);
    endfunction
endclass

module tb_top;
    import dscc_pkg::*;

    localparam int STALL_LIMIT   = 4000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 16;    // lets the pipeline finish its trailing work
    localparam int LONG_HOLD     = 300;   // receiver hold-off that fills the block
    localparam int PHASE_ITEMS   = 110;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [1:0]                i_func;
    logic [SERVO_W-1:0]        i_servo_index;
    logic signed [ANGLE_W-1:0] i_angle_first;
    logic signed [ANGLE_W-1:0] i_angle_second;
    logic [DUR_W-1:0]          i_duration_ms;
    logic                      empty;
    logic                      pop;
    logic                      o_event_kind;
    logic [SERVO_W-1:0]        o_out_servo;
    logic [DUTY_BITS_DEF-1:0]  o_duty;
    logic [DUR_W-1:0]          o_fade_ms;
    logic                      o_power_enable;
    logic                      o_last;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    servo_scoreboard sb = new();

    bit hold_request;  // raised by the sender, served once by the receiver
    bit hold_done;
    bit no_gaps;       // sender pushes back to back while set
    int burst_left;
    int idle_cycles;

    dual_servo_command_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_servo_index  (i_servo_index),
        .i_angle_first  (i_angle_first),
        .i_angle_second (i_angle_second),
        .i_duration_ms  (i_duration_ms),
        .empty          (empty),
        .pop            (pop),
        .o_event_kind   (o_event_kind),
        .o_out_servo    (o_out_servo),
        .o_duty         (o_duty),
        .o_fade_ms      (o_fade_ms),
        .o_power_enable (o_power_enable),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sample every handshake at the rising edge; the block updates its outputs
    // with nonblocking assignments, so these reads see the values of this edge.
    always @(posedge i_clk) begin : monitor
        t_servo_result seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (push && !full)
                sb.note_command(i_func, i_servo_index, i_angle_first, i_angle_second,
                                i_duration_ms);
            if (pop && !empty) begin
                seen.kind  = o_event_kind;
                seen.servo = o_out_servo;
                seen.duty  = o_duty;
                seen.fade  = o_fade_ms;
                seen.power = o_power_enable;
                seen.last  = o_last;
                sb.check_result(seen);
            end
        end
    end

    // Watchdog: end the run when no transaction of any kind moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, sb.pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver: at regular intervals pick a stall pattern at random (always pop, coin flip, sparse
    // single pops, alternating runs of pops and gaps); serve the one long hold-off on request.
    initial begin : receiver
        int cyc;
        int mode;
        pop  = 1'b0;
        cyc  = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                pop <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (cyc % 50 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= (cyc % 4 == 0);
                    default: pop <= cyc[2];
                endcase
                cyc++;
            end
        end
    end

    // Offer one command and hold it until the block takes it; leave push high
    // so a following command goes out back to back.
    task automatic send_command(input logic [1:0] func, input logic servo,
                                input logic signed [ANGLE_W-1:0] a1,
                                input logic signed [ANGLE_W-1:0] a2,
                                input logic [DUR_W-1:0] dur);
        push           <= 1'b1;
        i_func         <= func;
        i_servo_index  <= servo;
        i_angle_first  <= a1;
        i_angle_second <= a2;
        i_duration_ms  <= dur;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Send in bursts of random length with random gaps in between, or back to back while no_gaps is set.
    task automatic paced_send(input logic [1:0] func, input logic servo,
                              input logic signed [ANGLE_W-1:0] a1,
                              input logic signed [ANGLE_W-1:0] a2,
                              input logic [DUR_W-1:0] dur);
        if (!no_gaps) begin
            if (burst_left == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        send_command(func, servo, a1, a2, dur);
    endtask

    // Stop sending, wait for every pending result, then let the pipeline settle
    // so trailing ticks are done before any register write.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Write every register; trims carry random filler above bit 10, and one
    // write goes to an unused index, which the block must ignore.
    task automatic apply_settings(input int tl, input int tr, input bit il, input bit ir,
                                  input int idle);
        logic [CFG_DATA_W-1:0] d;
        drain();
        d = CFG_DATA_W'($urandom);
        d[TRIM_W-1:0] = tl[TRIM_W-1:0];
        write_reg(REG_TRIM_LEFT, d);
        d = CFG_DATA_W'($urandom);
        d[TRIM_W-1:0] = tr[TRIM_W-1:0];
        write_reg(REG_TRIM_RIGHT, d);
        d = CFG_DATA_W'($urandom);
        d[0] = il;
        write_reg(REG_INV_LEFT, d);
        d = CFG_DATA_W'($urandom);
        d[0] = ir;
        write_reg(REG_INV_RIGHT, d);
        write_reg(REG_IDLE_TIMEOUT, idle[CFG_DATA_W-1:0]);
        write_reg(CFG_IDX_W'(REG_IDLE_TIMEOUT + $urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return ANGLE_W'($urandom);
            1: return $urandom_range(0, 1) ? 13'h0fff : 13'h1000;
            2: return $urandom_range(0, 1) ? ANGLE_W'(3600) : ANGLE_W'(-3600);
            default: return ANGLE_W'(int'($urandom_range(0, 7200)) - 3600);
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return DUR_W'($urandom);
            1: return '0;
            default: return DUR_W'($urandom_range(0, 6));
        endcase
    endfunction

    // Well-formed sequences: a move, then a run of ticks that may or may not
    // outlast the countdown; now and then an unused function code as noise.
    task automatic run_phase(input int target);
        int sent;
        int run;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 11) == 0) begin
                paced_send(FUNC_UNUSED, 1'($urandom), ANGLE_W'($urandom),
                           ANGLE_W'($urandom), DUR_W'($urandom));
                sent++;
            end
            paced_send(($urandom_range(0, 2) == 0) ? FUNC_SYNC : FUNC_SINGLE, 1'($urandom),
                       pick_angle(), pick_angle(), pick_duration());
            run = $urandom_range(0, 12);
            repeat (run) paced_send(FUNC_TICK, 1'($urandom), ANGLE_W'($urandom),
                                    ANGLE_W'($urandom), DUR_W'($urandom));
            sent += run + 1;
        end
    endtask

    initial begin : stimulus
        int tl;
        int tr;
        int idle;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_func         = FUNC_SINGLE;
        i_servo_index  = '0;
        i_angle_first  = '0;
        i_angle_second = '0;
        i_duration_ms  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_TRIM_LEFT;
        i_cfg_data     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: defaults after reset; tick while off and an unused code give nothing.
        paced_send(FUNC_TICK, 1'b0, '0, '0, '0);
        paced_send(FUNC_UNUSED, 1'b1, 13'h0fff, 13'h1000, 16'hffff);
        paced_send(FUNC_SINGLE, 1'b0, 0, 0, 0);
        paced_send(FUNC_SINGLE, 1'b0, 1800, 0, 16'hffff);
        paced_send(FUNC_SINGLE, 1'b1, 0, 0, 1);
        paced_send(FUNC_SINGLE, 1'b1, 1800, 0, 0);
        paced_send(FUNC_SINGLE, 1'b0, 13'h1000, 0, 7);
        paced_send(FUNC_SINGLE, 1'b1, 13'h0fff, 0, 7);
        paced_send(FUNC_SINGLE, 1'b0, -3600, 0, 9);
        paced_send(FUNC_SINGLE, 1'b1, 3600, 0, 9);
        paced_send(FUNC_SYNC, 1'b0, 900, 899, 500);
        paced_send(FUNC_SYNC, 1'b1, 13'h1000, 13'h0fff, 0);
        paced_send(FUNC_SYNC, 1'b0, 13'h0fff, 13'h1000, 16'hffff);

        // Directed: zero idle timeout, so the power-off event comes within ticks.
        apply_settings(0, 0, 1'b0, 1'b0, 0);
        paced_send(FUNC_SINGLE, 1'b1, 450, 0, 0);
        paced_send(FUNC_TICK, 1'b0, '0, '0, '0);
        paced_send(FUNC_TICK, 1'b1, '0, '0, '0);
        paced_send(FUNC_SYNC, 1'b0, 100, 1700, 2);
        repeat (3) paced_send(FUNC_TICK, 1'b0, '0, '0, '0);

        // Directed: trim and inversion extremes drive both clamps.
        apply_settings(-1024, 1023, 1'b1, 1'b1, 3);
        paced_send(FUNC_SINGLE, 1'b0, 0, 0, 0);
        paced_send(FUNC_SINGLE, 1'b1, 1800, 0, 0);
        paced_send(FUNC_SYNC, 1'b0, 1800, 0, 1);
        repeat (5) paced_send(FUNC_TICK, 1'b0, '0, '0, '0);

        // Random phases, one setting each, drained before every change.
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: apply_settings(0, 0, 1'b0, 1'b0, $urandom_range(0, 8));
                1: apply_settings(-1024, 1023, 1'b1, 1'b1, 0);
                2: apply_settings(900, -900, 1'b1, 1'b0, 65535);
                3: begin
                    // Push back to back while the receiver holds off: fill the block.
                    apply_settings(-900, 900, 1'b0, 1'b1, 5);
                    no_gaps = 1'b1;
                    hold_request = 1'b1;
                end
                default: begin
                    tl   = int'($urandom_range(0, 2047)) - 1024;
                    tr   = int'($urandom_range(0, 2047)) - 1024;
                    idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 10);
                    apply_settings(tl, tr, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), idle);
                end
            endcase
            run_phase(PHASE_ITEMS);
            no_gaps = 1'b0;
        end

        drain();
        $display("Covered %0d single moves, %0d synchronous moves, %0d live ticks, %0d power-offs",
                 sb.n_moves, sb.n_syncs, sb.n_ticks, sb.n_events);
        $display("Checked %0d results over %0d register writes, %0d mismatches",
                 sb.n_results, sb.n_writes, sb.errors);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
